FILE: sv/siphash_pkg.sv
package siphash_pkg;

   // siphash initialisation constants
   localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
   localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
   localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
   localparam logic [63:0] SIP_C3 = 64'h7465646279746573;

   // finalisation constant xored into word two
   localparam logic [63:0] SIP_FIN_XOR = 64'h00000000000000ff;

   // register index, taken from paddr bit 3 (registers are 8 bytes apart)
   localparam logic KEY_LOW_IDX  = 1'b0;
   localparam logic KEY_HIGH_IDX = 1'b1;

   localparam int unsigned DATA_W = 8;
   localparam int unsigned HASH_W = 32;
   localparam int unsigned CSR_W  = 64;
   localparam int unsigned ADDR_W = 4;

   typedef logic [3:0][63:0] sip_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;    // take the request byte, load key on a fresh string
      logic fin_load;  // build the length word and xor it into word three
      logic round;     // one sipround on the state
      logic xor_m;     // xor the held message word into word zero after the round
      logic xor_ff;    // xor the finalisation constant into word two after the round
      logic capture;   // fold the state into the result register
   } sip_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_block;  // the request byte completes an eight-byte word
   } sip_status_type;

endpackage

FILE: sv/siphash_ctrl.sv
module siphash_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tuser,
   input  logic                        req_tlast,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  siphash_pkg::sip_status_type status,
   output siphash_pkg::sip_cmd_type    cmd
);
   import siphash_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BLK,
      ST_FLOAD,
      ST_FRND1,
      ST_FRND2,
      ST_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       last_ff, last_in;
   logic       valid_ff, valid_in;
   logic       accept;
   logic       out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign out_free   = ~valid_ff | rsp_tready;
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      valid_in = valid_ff & ~rsp_tready;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_tuser || req_tlast)) begin
               cmd.accept = 1'b1;
               last_in    = req_tlast;
               cnt_in     = 2'd0;
               if (req_tuser && status.need_block) begin
                  state_in = ST_BLK;
               end else if (req_tlast) begin
                  state_in = ST_FLOAD;
               end
            end
         end
         ST_BLK: begin
            cmd.round = 1'b1;
            cnt_in    = cnt_ff + 2'd1;
            if (cnt_ff == 2'd1) begin
               cmd.xor_m = 1'b1;
               cnt_in    = 2'd0;
               state_in  = last_ff ? ST_FLOAD : ST_IDLE;
            end
         end
         ST_FLOAD: begin
            cmd.fin_load = 1'b1;
            cnt_in       = 2'd0;
            state_in     = ST_FRND1;
         end
         ST_FRND1: begin
            cmd.round = 1'b1;
            cnt_in    = cnt_ff + 2'd1;
            if (cnt_ff == 2'd1) begin
               cmd.xor_m  = 1'b1;
               cmd.xor_ff = 1'b1;
               cnt_in     = 2'd0;
               state_in   = ST_FRND2;
            end
         end
         ST_FRND2: begin
            cmd.round = 1'b1;
            cnt_in    = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.capture = 1'b1;
               valid_in    = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 2'd0;
         last_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
         valid_ff <= valid_in;
      end
   end

   a_blk_entry: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser && status.need_block) |=> (state_ff == ST_BLK))
      else $error("word completion did not start the compression rounds");

   a_capture_free: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> (~valid_ff | rsp_tready))
      else $error("result captured over an untaken result");

   a_two_rounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BLK || state_ff == ST_FRND1) |-> (cnt_ff <= 2'd1))
      else $error("compression round count overran");

   a_fin_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FRND2 && cnt_ff == 2'd3) |=> (state_ff == ST_DONE))
      else $error("finalisation rounds did not end in the result state");

endmodule

FILE: sv/siphash_dp.sv
module siphash_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  siphash_pkg::sip_cmd_type            cmd,
   output siphash_pkg::sip_status_type         status,
   input  logic [siphash_pkg::DATA_W-1:0]      req_tdata,
   input  logic                                req_tuser,
   input  logic [63:0]                         key_low,
   input  logic [63:0]                         key_high,
   output logic [siphash_pkg::HASH_W-1:0]      rsp_tdata
);
   import siphash_pkg::*;

   function automatic sip_state_type sip_round(input sip_state_type v);
      logic [63:0] a, b, c, d;
      sip_state_type r;
      a = v[0] + v[1];
      b = {v[1][50:0], v[1][63:51]} ^ a;
      a = {a[31:0], a[63:32]};
      c = v[2] + v[3];
      d = {v[3][47:0], v[3][63:48]} ^ c;
      a = a + d;
      d = {d[42:0], d[63:43]} ^ a;
      c = c + b;
      b = {b[46:0], b[63:47]} ^ c;
      c = {c[31:0], c[63:32]};
      r[0] = a;
      r[1] = b;
      r[2] = c;
      r[3] = d;
      return r;
   endfunction

   sip_state_type v_ff, v_in, base, init;
   logic [63:0]   m_ff, m_in, fin_m;
   logic [55:0]   partial_ff, partial_in;
   logic [2:0]    pos_ff, pos_in;
   logic [7:0]    len_ff, len_in;
   logic          in_string_ff, in_string_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [63:0]   fold;

   assign init[0] = SIP_C0 ^ key_low;
   assign init[1] = SIP_C1 ^ key_high;
   assign init[2] = SIP_C2 ^ key_low;
   assign init[3] = SIP_C3 ^ key_high;
   assign base    = in_string_ff ? v_ff : init;
   assign fin_m   = {len_ff, partial_ff};
   assign fold    = v_ff[0] ^ v_ff[1] ^ v_ff[2] ^ v_ff[3];

   assign status.need_block = req_tuser & (pos_ff == 3'd7);
   assign rsp_tdata         = hash_ff;

   always_comb begin
      v_in         = v_ff;
      m_in         = m_ff;
      partial_in   = partial_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      in_string_in = in_string_ff;
      hash_in      = hash_ff;
      if (cmd.accept) begin
         v_in         = base;
         in_string_in = 1'b1;
         if (req_tuser) begin
            len_in = len_ff + 8'd1;
            if (pos_ff == 3'd7) begin
               m_in       = {req_tdata, partial_ff};
               v_in[3]    = base[3] ^ {req_tdata, partial_ff};
               partial_in = '0;
               pos_in     = 3'd0;
            end else begin
               for (int i = 0; i < 7; i++) begin
                  if (pos_ff == 3'(i)) begin
                     partial_in[8*i +: 8] = req_tdata;
                  end
               end
               pos_in = pos_ff + 3'd1;
            end
         end
      end
      if (cmd.fin_load) begin
         m_in         = fin_m;
         v_in[3]      = v_ff[3] ^ fin_m;
         partial_in   = '0;
         pos_in       = 3'd0;
         len_in       = 8'd0;
         in_string_in = 1'b0;
      end
      if (cmd.round) begin
         v_in = sip_round(v_ff);
         if (cmd.xor_m) begin
            v_in[0] = v_in[0] ^ m_ff;
         end
         if (cmd.xor_ff) begin
            v_in[2] = v_in[2] ^ SIP_FIN_XOR;
         end
      end
      if (cmd.capture) begin
         hash_in = fold[HASH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff   <= '0;
         pos_ff       <= 3'd0;
         len_ff       <= 8'd0;
         in_string_ff <= 1'b0;
      end else begin
         partial_ff   <= partial_in;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         in_string_ff <= in_string_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      m_ff    <= m_in;
      hash_ff <= hash_in;
   end

endmodule

FILE: sv/siphash24_string_hash_bytes.sv
// siphash-2-4 over a byte string, one byte per request, giving the low 32 bits of the
// 64-bit hash on the request marked tlast. a request with tuser low and tlast low is
// ignored; tuser low with tlast high ends the string without a byte (alone it hashes the
// empty string). the 128-bit key sits in two 64-bit registers (key low at 0x0, key high
// at 0x8), both reset to zero, and is picked up on the first request of each string.
// timing: one sipround unit is shared by all rounds and does one round per cycle. a byte
// that completes an eight-byte word adds two compression rounds, during which no request
// is taken. the tlast request adds the length word load, two rounds, four finalisation
// rounds and the result fold, after the compression rounds if its byte ends a word.
// the result waits in an output register, so a new string can start while still pending.
module siphash24_string_hash_bytes (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [siphash_pkg::DATA_W-1:0]      req_tdata,   // [7:0] data_byte
   input  logic                                req_tuser,   // [0] byte_present
   input  logic                                req_tlast,   // end of string
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [siphash_pkg::HASH_W-1:0]      rsp_tdata,   // [31:0] hash_value
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [siphash_pkg::ADDR_W-1:0]      csr_paddr,
   input  logic [siphash_pkg::CSR_W-1:0]       csr_pwdata,
   output logic [siphash_pkg::CSR_W-1:0]       csr_prdata,
   output logic                                csr_pready
);
   import siphash_pkg::*;

   logic [63:0]    key_low_ff, key_low_in;
   logic [63:0]    key_high_ff, key_high_in;
   logic           csr_wr;
   logic           csr_idx;
   sip_cmd_type    cmd;
   sip_status_type status;

   // register port, no wait states
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[3];

   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            KEY_LOW_IDX:  key_low_in  = csr_pwdata;
            KEY_HIGH_IDX: key_high_in = csr_pwdata;
            default:      key_low_in  = key_low_ff;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (csr_idx)
         KEY_LOW_IDX:  csr_prdata = key_low_ff;
         KEY_HIGH_IDX: csr_prdata = key_high_ff;
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
      end
   end

   // sequencer: request acceptance, round counting, result handshake
   siphash_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // state words, pending bytes, length and the round unit
   siphash_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .key_low   (key_low_ff),
      .key_high  (key_high_ff),
      .rsp_tdata (rsp_tdata)
   );

endmodule
